/* src/framed_packet_receiver_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet receiver checker
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fpr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_pkg
// Shared constants and the job record passed from front end to back end.
// ---------------------------------------------------------------------------
package fpr_pkg;

    localparam int BUF_DEPTH_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int REPLY_BEATS     = 6;

    localparam logic [7:0] HDR0_BYTE   = 8'h55;
    localparam logic [7:0] HDR1_BYTE   = 8'hAA;
    localparam logic [7:0] ACK_CODE    = 8'h80;
    localparam logic [7:0] SUMERR_CODE = 8'h81;
    localparam logic [7:0] XORERR_CODE = 8'h82;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_SUM_FAIL = 2'd1;
    localparam logic [1:0] STATUS_XOR_FAIL = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic [1:0] status;
        logic [7:0] rdata;
        logic [7:0] length;
        logic       valid_flag;
    } fpr_job_t;

endpackage

/* src/fpr_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_in_if / fpr_out_if
// Valid/ready channels for received items and for result items.
// ---------------------------------------------------------------------------
interface fpr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [5:0] read_index;

    modport source (output valid, command, rx_byte, read_index, input ready);
    modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

interface fpr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [1:0] frame_status;
    logic [7:0] read_data;
    logic [7:0] frame_length;
    logic       frame_valid;

    modport source (output valid, result_kind, tx_byte, tx_last, frame_status,
                    read_data, frame_length, frame_valid, input ready);
    modport sink   (input valid, result_kind, tx_byte, tx_last, frame_status,
                    read_data, frame_length, frame_valid, output ready);
endinterface

/* src/fpr_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_front
// Frame parser: runs the header/length/checksum sequence, writes the payload
// buffer, reads it for read commands and stages one job per reply or read.
// ---------------------------------------------------------------------------
module fpr_front #(
    parameter int BUF_DEPTH = fpr_pkg::BUF_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    fpr_in_if.sink           req,
    output fpr_pkg::fpr_job_t job,
    output logic             job_valid,
    input  logic             job_ready
);
    import fpr_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int IW = (AW > 6) ? AW : 6;

    localparam logic [2:0] STEP_HUNT = 3'd0;
    localparam logic [2:0] STEP_HDR1 = 3'd1;
    localparam logic [2:0] STEP_CODE = 3'd2;
    localparam logic [2:0] STEP_LEN  = 3'd3;
    localparam logic [2:0] STEP_DATA = 3'd4;
    localparam logic [2:0] STEP_SUM  = 3'd5;
    localparam logic [2:0] STEP_XOR  = 3'd6;

    logic [7:0] mem [BUF_DEPTH];

    logic [2:0] step_reg, step_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] xor_reg, xor_next;
    logic       flag_reg, flag_next;

    logic       job_valid_reg, job_valid_next;
    logic       job_kind_reg;
    logic [7:0] job_code_reg;
    logic [1:0] job_status_reg;
    logic [7:0] job_len_reg;
    logic       job_flag_reg;
    logic       rd_zero_reg;
    logic [7:0] mem_rd_reg;

    logic          accept;
    logic          emit;
    logic [7:0]    emit_code;
    logic [1:0]    emit_status;
    logic          store;
    logic          wr_en;
    logic [IW-1:0] idx_w;
    logic          idx_in_range;
    logic          cnt_in_range;

    assign req.ready = !job_valid_reg || job_ready;
    assign accept    = req.valid && req.ready;

    assign idx_w        = IW'(req.read_index);
    assign idx_in_range = ({1'b0, idx_w} < (IW + 1)'(BUF_DEPTH));
    assign cnt_in_range = ({1'b0, count_reg} < 9'(BUF_DEPTH));

    always_comb
    begin
        step_next   = step_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        xor_next    = xor_reg;
        flag_next   = flag_reg;
        emit        = 1'b0;
        emit_code   = ACK_CODE;
        emit_status = STATUS_GOOD;
        store       = 1'b0;
        case (step_reg)
            STEP_HDR1:
            begin
                if (req.rx_byte == HDR1_BYTE)
                begin
                    step_next  = STEP_CODE;
                    count_next = 8'd0;
                    flag_next  = 1'b0;
                end
                else
                begin
                    step_next = STEP_HUNT;
                end
            end
            STEP_CODE:
            begin
                sum_next   = req.rx_byte;
                xor_next   = req.rx_byte;
                store      = 1'b1;
                count_next = count_reg + 8'd1;
                step_next  = STEP_LEN;
            end
            STEP_LEN:
            begin
                sum_next  = sum_reg + req.rx_byte;
                xor_next  = xor_reg ^ req.rx_byte;
                len_next  = req.rx_byte;
                step_next = (req.rx_byte == 8'd0) ? STEP_SUM : STEP_DATA;
            end
            STEP_DATA:
            begin
                sum_next   = sum_reg + req.rx_byte;
                xor_next   = xor_reg ^ req.rx_byte;
                store      = 1'b1;
                step_next  = (count_reg == len_reg) ? STEP_SUM : STEP_DATA;
                count_next = count_reg + 8'd1;
            end
            STEP_SUM:
            begin
                if (sum_reg == req.rx_byte)
                begin
                    step_next = STEP_XOR;
                end
                else
                begin
                    step_next   = STEP_HUNT;
                    count_next  = 8'd0;
                    sum_next    = 8'd0;
                    xor_next    = 8'd0;
                    emit        = 1'b1;
                    emit_code   = SUMERR_CODE;
                    emit_status = STATUS_SUM_FAIL;
                end
            end
            STEP_XOR:
            begin
                step_next  = STEP_HUNT;
                count_next = 8'd0;
                sum_next   = 8'd0;
                xor_next   = 8'd0;
                emit       = 1'b1;
                if (xor_reg == req.rx_byte)
                begin
                    flag_next   = 1'b1;
                    emit_code   = ACK_CODE;
                    emit_status = STATUS_GOOD;
                end
                else
                begin
                    emit_code   = XORERR_CODE;
                    emit_status = STATUS_XOR_FAIL;
                end
            end
            default:
            begin
                step_next = (req.rx_byte == HDR0_BYTE) ? STEP_HDR1 : STEP_HUNT;
            end
        endcase
    end

    assign wr_en = accept && (req.command == CMD_BYTE) && store && cnt_in_range;

    always_comb
    begin
        if (accept)
        begin
            job_valid_next = (req.command == CMD_READ) || emit;
        end
        else if (job_ready)
        begin
            job_valid_next = 1'b0;
        end
        else
        begin
            job_valid_next = job_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_HUNT;
            count_reg     <= 8'd0;
            len_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            flag_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            if (accept && (req.command == CMD_BYTE))
            begin
                step_reg  <= step_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                sum_reg   <= sum_next;
                xor_reg   <= xor_next;
                flag_reg  <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= req.rx_byte;
        end
        if (accept && (req.command == CMD_READ))
        begin
            mem_rd_reg <= mem[idx_w[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_zero_reg <= !idx_in_range;
            if (req.command == CMD_READ)
            begin
                job_kind_reg   <= KIND_READ;
                job_code_reg   <= 8'd0;
                job_status_reg <= STATUS_GOOD;
                job_len_reg    <= len_reg;
                job_flag_reg   <= flag_reg;
            end
            else
            begin
                job_kind_reg   <= KIND_REPLY;
                job_code_reg   <= emit_code;
                job_status_reg <= emit_status;
                job_len_reg    <= len_next;
                job_flag_reg   <= flag_next;
            end
        end
    end

    assign job_valid      = job_valid_reg;
    assign job.kind       = job_kind_reg;
    assign job.code       = job_code_reg;
    assign job.status     = job_status_reg;
    assign job.rdata      = (job_kind_reg == KIND_READ && !rd_zero_reg) ? mem_rd_reg : 8'd0;
    assign job.length     = job_len_reg;
    assign job.valid_flag = job_flag_reg;

endmodule

/* src/fpr_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_queue
// Small job FIFO between the parser and the reply sequencer.
// ---------------------------------------------------------------------------
module fpr_queue #(
    parameter int DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  fpr_pkg::fpr_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output fpr_pkg::fpr_job_t pop_data
);
    import fpr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fpr_job_t slots [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/fpr_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_back
// Reply sequencer: expands a reply job into six bytes and a read job into
// one answer, through a registered result stage.
// ---------------------------------------------------------------------------
module fpr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  fpr_pkg::fpr_job_t job,
    fpr_out_if.source         rsp
);
    import fpr_pkg::*;

    localparam logic [2:0] LAST_BEAT = 3'(REPLY_BEATS - 1);

    fpr_job_t   cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] beat_reg, beat_next;
    logic       out_valid_reg, out_valid_next;

    logic       out_kind_reg;
    logic [7:0] out_tx_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_rdata_reg;
    logic [7:0] out_len_reg;
    logic       out_flag_reg;

    logic       load_out;
    logic       last_beat;
    logic       done;
    logic       pop;
    logic [7:0] reply_byte;

    assign load_out  = cur_valid_reg && (!out_valid_reg || rsp.ready);
    assign last_beat = (cur_reg.kind == KIND_READ) || (beat_reg == LAST_BEAT);
    assign done      = load_out && last_beat;
    assign job_ready = !cur_valid_reg || done;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        case (beat_reg)
            3'd0:    reply_byte = HDR0_BYTE;
            3'd1:    reply_byte = HDR1_BYTE;
            3'd2:    reply_byte = cur_reg.code;
            3'd3:    reply_byte = 8'd0;
            3'd4:    reply_byte = cur_reg.code;
            3'd5:    reply_byte = cur_reg.code;
            default: reply_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        beat_next      = beat_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            beat_next      = 3'd0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            beat_next = beat_reg + 3'd1;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= job;
        end
        if (load_out)
        begin
            out_kind_reg <= cur_reg.kind;
            out_len_reg  <= cur_reg.length;
            out_flag_reg <= cur_reg.valid_flag;
            if (cur_reg.kind == KIND_READ)
            begin
                out_tx_reg     <= 8'd0;
                out_last_reg   <= 1'b0;
                out_status_reg <= STATUS_GOOD;
                out_rdata_reg  <= cur_reg.rdata;
            end
            else
            begin
                out_tx_reg     <= reply_byte;
                out_last_reg   <= (beat_reg == LAST_BEAT);
                out_status_reg <= cur_reg.status;
                out_rdata_reg  <= 8'd0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_kind  = out_kind_reg;
    assign rsp.tx_byte      = out_tx_reg;
    assign rsp.tx_last      = out_last_reg;
    assign rsp.frame_status = out_status_reg;
    assign rsp.read_data    = out_rdata_reg;
    assign rsp.frame_length = out_len_reg;
    assign rsp.frame_valid  = out_flag_reg;

endmodule

/* src/framed_packet_receiver_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// framed_packet_receiver_unit
// Serial frame receiver with sum/XOR check, six-byte replies and a payload
// buffer readable by command.
// ---------------------------------------------------------------------------
// The block takes one item per cycle on req: a received byte or a buffer read.
// Frames are 55 AA CODE LEN DATA[LEN] SUM XOR; each frame end produces six
// reply results (ACK 80, sum error 81 or XOR error 82), each read produces one
// answer. The parser stages each job in a register and hands it to a job
// queue of QUEUE_DEPTH entries; the reply sequencer drives one result per
// cycle while rsp is ready, from its output register, and req stalls only
// once the queue and staging register are full. A read answer or the first
// reply byte passes, at the earliest, through the staging register with the
// buffer read, the job queue, the sequencer job register, then the result
// register. The payload buffer needs no clearing after reset; entries never
// written by a frame read back undefined.
// ---------------------------------------------------------------------------
module framed_packet_receiver_unit #(
    parameter int BUF_DEPTH   = fpr_pkg::BUF_DEPTH_DEF,
    parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fpr_in_if.sink    req,
    fpr_out_if.source rsp
);
    import fpr_pkg::*;

    fpr_job_t front_job;
    logic     front_valid;
    logic     front_ready;
    fpr_job_t back_job;
    logic     back_valid;
    logic     back_ready;

    fpr_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    fpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    fpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .rsp       (rsp)
    );

endmodule

/* src/fpr_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpr_checker
// Port-level checks on the result channel of the frame receiver.
// ---------------------------------------------------------------------------
`include "framed_packet_receiver_unit_assert.svh"

module fpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_kind,
    input logic [7:0] rsp_tx_byte,
    input logic       rsp_tx_last,
    input logic [1:0] rsp_status,
    input logic [7:0] rsp_read_data,
    input logic       rsp_frame_valid
);
    import fpr_pkg::*;

    `FPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_read_data), "result changed while stalled")
    `FPR_ASSERT_NOW(a_last_code, rsp_valid && rsp_tx_last, rsp_kind == KIND_REPLY && rsp_tx_byte == (ACK_CODE | {6'd0, rsp_status}), "last reply byte does not match status")
    `FPR_ASSERT_NOW(a_read_clean, rsp_valid && rsp_kind == KIND_READ, rsp_tx_byte == 8'd0 && !rsp_tx_last && rsp_status == STATUS_GOOD, "read answer carries reply fields")
    `FPR_ASSERT_NOW(a_ack_flag, rsp_valid && rsp_kind == KIND_REPLY && rsp_status == STATUS_GOOD, rsp_frame_valid, "acknowledge without frame-valid flag")

endmodule

bind framed_packet_receiver_unit fpr_checker u_fpr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_kind        (rsp.result_kind),
    .rsp_tx_byte     (rsp.tx_byte),
    .rsp_tx_last     (rsp.tx_last),
    .rsp_status      (rsp.frame_status),
    .rsp_read_data   (rsp.read_data),
    .rsp_frame_valid (rsp.frame_valid)
);
